[rtl/core/slcan_pkg.sv]
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, character codes and the hex digit decoder for the SLCAN
// line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slcan_pkg;

	// character codes
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_STD_LO  = 8'h74; // 't'
	localparam logic [7:0] CHAR_STD_UP  = 8'h54; // 'T'

	// number of data byte fields in a frame on the output bus
	localparam int unsigned FRAME_BYTES = 8;

	// line layout
	localparam int unsigned POS_LEN   = 4;
	localparam int unsigned POS_DATA  = 5;
	localparam int unsigned MIN_CHARS = 5;

	// one classified character as it travels from the front to the back
	typedef struct packed {
		logic       eol;    // CR or LF
		logic       is_std; // 't' or 'T'
		logic [3:0] nib;    // hex value, 0 for a non-hex character
	} item_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [3:0] res;
		res = 4'h0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			res = 4'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			res = 4'(ch - 8'h37);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			res = 4'(ch - 8'h57);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/core/slcan_front.sv]
// ----------------------------------------------------------------------------
// slcan_front
// Input stage: accepts characters and registers their classification.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_char,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output slcan_pkg::item_t        out_item
);
	import slcan_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_next;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_comb begin
		item_next.eol    = (in_char == CHAR_CR) || (in_char == CHAR_LF);
		item_next.is_std = (in_char == CHAR_STD_LO) || (in_char == CHAR_STD_UP);
		item_next.nib    = hex_nibble(in_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_next;
		end
	end

endmodule

`default_nettype wire

[rtl/core/slcan_fifo.sv]
// ----------------------------------------------------------------------------
// slcan_fifo
// Two-entry queue between the classifying front and the frame back end.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire slcan_pkg::item_t   push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output slcan_pkg::item_t        pop_item,
	output logic [1:0]              level
);
	import slcan_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign level      = count_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[rtl/core/slcan_back.sv]
// ----------------------------------------------------------------------------
// slcan_back
// Line assembler: tracks the line position, collects id, length and data
// nibbles, checks the line at CR/LF and registers the finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_back #(
	parameter int unsigned LINE_BYTES = 32,
	parameter int unsigned MAX_DATA   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire slcan_pkg::item_t   in_item,
	output logic                    frame_valid,
	input  wire logic               frame_ready,
	output logic [11:0]             frame_id,
	output logic [3:0]              frame_len,
	output logic [slcan_pkg::FRAME_BYTES*8-1:0] frame_payload
);
	import slcan_pkg::*;

	localparam int unsigned CW          = $clog2(LINE_BYTES);
	localparam int unsigned STORE_DEPTH = LINE_BYTES - 1;
	localparam int unsigned CMP_W       = (CW > 6) ? CW : 6;

	logic [CW-1:0] count_q;
	logic          first_ok_q;
	logic [11:0]   id_q;
	logic [3:0]    len_q;
	logic [7:0]    data_q [MAX_DATA];

	logic          out_valid_q;
	logic [11:0]   out_id_q;
	logic [3:0]    out_len_q;
	logic [FRAME_BYTES*8-1:0] out_data_q;

	logic             take;
	logic             store_char;
	logic             line_ok;
	logic [CMP_W-1:0] need_chars;
	logic [CMP_W-1:0] have_chars;
	logic [FRAME_BYTES*8-1:0] masked_data;

	assign in_ready      = !out_valid_q || frame_ready;
	assign take          = in_valid && in_ready;
	assign store_char    = !in_item.eol && (count_q < CW'(STORE_DEPTH));
	assign frame_valid   = out_valid_q;
	assign frame_id      = out_id_q;
	assign frame_len     = out_len_q;
	assign frame_payload = out_data_q;

	// line check at CR/LF
	always_comb begin
		need_chars = CMP_W'(MIN_CHARS) + (CMP_W'(len_q) << 1);
		have_chars = CMP_W'(count_q);
		line_ok    = (count_q != '0) && first_ok_q
			&& (have_chars >= CMP_W'(MIN_CHARS))
			&& (len_q <= 4'(MAX_DATA))
			&& (have_chars >= need_chars);
	end

	// bytes at or beyond the length read as zero
	for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_mask
		if (k < MAX_DATA) begin : g_used
			assign masked_data[k*8 +: 8] = (4'(k) < len_q) ? data_q[k] : 8'h00;
		end else begin : g_unused
			assign masked_data[k*8 +: 8] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && in_item.eol && line_ok) begin
				out_valid_q <= 1'b1;
			end else if (frame_valid && frame_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (in_item.eol) begin
					count_q <= '0;
				end else if (store_char) begin
					count_q <= count_q + CW'(1);
				end else begin
					// buffer full: drop the character and restart the line
					count_q <= '0;
				end
			end
		end
	end

	// header fields and data nibbles of the line under assembly, high digit first
	always_ff @(posedge clk) begin
		if (take && store_char) begin
			if (count_q == CW'(0)) first_ok_q <= in_item.is_std;
			if (count_q == CW'(1)) id_q[11:8] <= in_item.nib;
			if (count_q == CW'(2)) id_q[7:4]  <= in_item.nib;
			if (count_q == CW'(3)) id_q[3:0]  <= in_item.nib;
			if (count_q == CW'(POS_LEN)) len_q <= in_item.nib;
			for (int k = 0; k < MAX_DATA; k++) begin
				if (count_q == CW'(POS_DATA + 2*k))     data_q[k][7:4] <= in_item.nib;
				if (count_q == CW'(POS_DATA + 2*k + 1)) data_q[k][3:0] <= in_item.nib;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_item.eol && line_ok) begin
			out_id_q   <= id_q;
			out_len_q  <= len_q;
			out_data_q <= masked_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/slcan_line_to_can_frame_parser_unit.sv]
// end of line: a taken CR/LF passes the front register, a queue slot and the
//   output register before m_tvalid rises
// throughput: one character per cycle, sustained while the frame output is taken
// a waiting frame holds the output register; the 2-entry queue and the front
//   register keep taking characters until they fill
// reset: arst_n clears the line position, queue and valid flags at once
// ----------------------------------------------------------------------------
// slcan_line_to_can_frame_parser_unit
// Parses SLCAN 't'/'T' lines from an ASCII character stream into CAN frames.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_line_to_can_frame_parser_unit #(
	parameter int unsigned LINE_BYTES = 32, // line buffer size, holds LINE_BYTES-1 chars
	parameter int unsigned MAX_DATA   = 8   // largest accepted data length
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_char
	// frame output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata   // [11:0] frame_id, [15:12] frame_len,
	                                   // [23:16] byte0 .. [79:72] byte7
);
	import slcan_pkg::*;

	// front to queue
	logic  fr_valid;
	logic  fr_ready;
	item_t fr_item;

	// queue to back end
	logic       q_valid;
	logic       q_ready;
	item_t      q_item;
	logic [1:0] q_level;

	logic [11:0]              frame_id;
	logic [3:0]               frame_len;
	logic [FRAME_BYTES*8-1:0] frame_payload;

	// classify each character and register it
	slcan_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	// short queue so the front keeps taking characters while a frame waits
	slcan_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item),
		.level      (q_level)
	);

	// line assembly, check at end of line, output register
	slcan_back #(
		.LINE_BYTES (LINE_BYTES),
		.MAX_DATA   (MAX_DATA)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_ready      (q_ready),
		.in_item       (q_item),
		.frame_valid   (m_tvalid),
		.frame_ready   (m_tready),
		.frame_id      (frame_id),
		.frame_len     (frame_len),
		.frame_payload (frame_payload)
	);

	assign m_tdata = {frame_payload, frame_len, frame_id};

`ifndef SYNTHESIS
	// the queue never holds more than its two slots
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level != 2'd3)
		else $error("queue level out of range");

	// a new frame only follows a CR/LF leaving the queue
	a_frame_from_eol: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(q_valid && q_ready && q_item.eol))
		else $error("frame without end of line");

	// the length of a frame never exceeds the data limit
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] <= 4'(MAX_DATA)))
		else $error("frame length above limit");

	// a frame without data carries all-zero data bytes
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15:12] == 4'd0) |-> (m_tdata[79:16] == 64'd0))
		else $error("unused data bytes not zero");
`endif

endmodule

`default_nettype wire
